// ===== hdl/pcm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm_pkg: shared types for the priority command mux
// Item and result words, action codes, controller states and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package pcm_pkg;

	// action codes of an input word
	typedef enum logic [1:0] {
		ACT_CONNECT    = 2'd0,
		ACT_DISCONNECT = 2'd1,
		ACT_COMMAND    = 2'd2,
		ACT_IGNORED    = 2'd3
	} action_t;

	// input word
	typedef struct packed {
		action_t     action;
		logic [7:0]  source_id;
		logic [3:0]  priority_req;
		logic [31:0] timeout_ticks;
		logic [31:0] time_now;
		logic [63:0] payload;
	} item_t;

	// result word
	typedef struct packed {
		logic        done_ok;
		logic        forward;
		logic [63:0] cmd_out;
	} result_t;

	// controller states
	typedef enum logic [1:0] {
		ST_IDLE  = 2'd0,
		ST_SCAN  = 2'd1,
		ST_DRAIN = 2'd2,
		ST_APPLY = 2'd3
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic scan_en;
		logic apply;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_last;
	} dp_status_t;

endpackage

// ===== hdl/pcm_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm_ctrl: sequencer of the priority command mux
// Takes a word, walks the datapath through the slot scan, a drain
// state for the registered read, and the update and result cycle.
// ----------------------------------------------------------------------------
module pcm_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	output pcm_pkg::ctrl_cmd_t  cmd,
	input  pcm_pkg::dp_status_t status
);

	pcm_pkg::state_t state_q;
	pcm_pkg::state_t state_nxt;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pcm_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			pcm_pkg::ST_IDLE: begin
				if (start) begin
					state_nxt = pcm_pkg::ST_SCAN;
				end
			end
			pcm_pkg::ST_SCAN: begin
				if (status.scan_last) begin
					state_nxt = pcm_pkg::ST_DRAIN;
				end
			end
			pcm_pkg::ST_DRAIN: begin
				state_nxt = pcm_pkg::ST_APPLY;
			end
			pcm_pkg::ST_APPLY: begin
				state_nxt = pcm_pkg::ST_IDLE;
			end
			default: begin
				state_nxt = pcm_pkg::ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		case (state_q)
			pcm_pkg::ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			pcm_pkg::ST_SCAN: begin
				cmd.scan_en = 1'b1;
			end
			pcm_pkg::ST_DRAIN: begin
				cmd = '0;
			end
			pcm_pkg::ST_APPLY: begin
				cmd.apply = 1'b1;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// a taken word always starts a scan
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == pcm_pkg::ST_SCAN))
		else $error("pcm_ctrl: load not followed by scan");

	// the update cycle is always followed by idle
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.apply |=> !busy)
		else $error("pcm_ctrl: still busy after update");

endmodule

// ===== hdl/pcm_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm_datapath: slot table and scan logic of the priority command mux
// Holds the slot flags and the source, timeout and stamp memories.
// A top-down scan finds the word's source and whether a higher slot
// is still active, then the update cycle writes the table and result.
// ----------------------------------------------------------------------------
module pcm_datapath #(
	parameter int LEVELS       = 16,
	parameter int PAYLOAD_BITS = 64,
	parameter int TIME_BITS    = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  pcm_pkg::ctrl_cmd_t  cmd,
	output pcm_pkg::dp_status_t status,
	input  pcm_pkg::item_t      item,
	output pcm_pkg::result_t    result,
	output logic                done
);

	localparam int LVL_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;

	// slot flags
	logic [LEVELS-1:0] used_q;
	logic [LEVELS-1:0] heard_q;

	// slot memories
	logic [7:0]           src_mem   [LEVELS];
	logic [TIME_BITS-1:0] tmo_mem   [LEVELS];
	logic [TIME_BITS-1:0] stamp_mem [LEVELS];

	// captured word and scan state
	pcm_pkg::item_t       item_q;
	logic [LVL_W-1:0]     idx_q;
	logic [LVL_W-1:0]     idx_s1;
	logic                 vld_s1;
	logic [7:0]           src_s1;
	logic [TIME_BITS-1:0] tmo_s1;
	logic [TIME_BITS-1:0] stamp_s1;
	logic                 found_q;
	logic [LVL_W-1:0]     at_q;
	logic                 blocked_q;
	logic                 active_q;

	pcm_pkg::result_t     result_q;
	pcm_pkg::result_t     result_nxt;
	logic                 done_q;

	logic [TIME_BITS-1:0] now_t;
	logic [TIME_BITS-1:0] elapsed;
	logic                 slot_match;
	logic                 slot_active;
	logic                 prio_ok;
	logic [LVL_W-1:0]     prio_idx;

	assign now_t       = TIME_BITS'(item_q.time_now);
	assign elapsed     = now_t - stamp_s1;
	assign slot_match  = used_q[idx_s1] && (src_s1 == item_q.source_id);
	assign slot_active = used_q[idx_s1] && heard_q[idx_s1] && (elapsed < tmo_s1);
	assign prio_ok     = (32'(item_q.priority_req) < LEVELS);
	assign prio_idx    = LVL_W'(item_q.priority_req);

	assign status.scan_last = (idx_q == '0);

	// word capture and scan index, highest level first
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= item;
			idx_q  <= LVL_W'(LEVELS - 1);
		end else if (cmd.scan_en) begin
			idx_q  <= idx_q - LVL_W'(1);
		end
	end

	// registered memory reads
	always_ff @(posedge clk) begin
		if (cmd.scan_en) begin
			src_s1   <= src_mem[idx_q];
			tmo_s1   <= tmo_mem[idx_q];
			stamp_s1 <= stamp_mem[idx_q];
			idx_s1   <= idx_q;
		end
	end

	// scan control flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			found_q   <= 1'b0;
			active_q  <= 1'b0;
			blocked_q <= 1'b0;
			at_q      <= '0;
		end else begin
			vld_s1 <= cmd.scan_en;
			if (cmd.load) begin
				found_q   <= 1'b0;
				active_q  <= 1'b0;
				blocked_q <= 1'b0;
			end else if (vld_s1) begin
				if (slot_match && !found_q) begin
					found_q   <= 1'b1;
					at_q      <= idx_s1;
					blocked_q <= active_q;
				end
				if (slot_active) begin
					active_q <= 1'b1;
				end
			end
		end
	end

	// memory writes on update
	always_ff @(posedge clk) begin
		if (cmd.apply) begin
			if (item_q.action == pcm_pkg::ACT_CONNECT && prio_ok && !found_q
				&& !used_q[prio_idx]) begin
				src_mem[prio_idx] <= item_q.source_id;
				tmo_mem[prio_idx] <= TIME_BITS'(item_q.timeout_ticks);
			end
			if (item_q.action == pcm_pkg::ACT_COMMAND && found_q) begin
				stamp_mem[at_q] <= now_t;
			end
		end
	end

	// result word of the update cycle
	always_comb begin
		result_nxt = '0;
		case (item_q.action)
			pcm_pkg::ACT_CONNECT: begin
				if (prio_ok && ((!found_q && !used_q[prio_idx])
					|| (found_q && at_q == prio_idx))) begin
					result_nxt.done_ok = 1'b1;
				end
			end
			pcm_pkg::ACT_DISCONNECT: begin
				result_nxt.done_ok = found_q;
			end
			pcm_pkg::ACT_COMMAND: begin
				if (found_q && !blocked_q) begin
					result_nxt.done_ok = 1'b1;
					result_nxt.forward = 1'b1;
					result_nxt.cmd_out = 64'(PAYLOAD_BITS'(item_q.payload));
				end
			end
			default: begin
				result_nxt = '0;
			end
		endcase
	end

	// slot flags and result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q   <= '0;
			heard_q  <= '0;
			done_q   <= 1'b0;
			result_q <= '0;
		end else begin
			done_q <= cmd.apply;
			if (cmd.apply) begin
				result_q <= result_nxt;
				case (item_q.action)
					pcm_pkg::ACT_CONNECT: begin
						if (prio_ok && !found_q && !used_q[prio_idx]) begin
							used_q[prio_idx]  <= 1'b1;
							heard_q[prio_idx] <= 1'b0;
						end
					end
					pcm_pkg::ACT_DISCONNECT: begin
						if (found_q) begin
							used_q[at_q]  <= 1'b0;
							heard_q[at_q] <= 1'b0;
						end
					end
					pcm_pkg::ACT_COMMAND: begin
						if (found_q) begin
							heard_q[at_q] <= 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	assign result = result_q;
	assign done   = done_q;

	// an update always yields exactly one result word
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.apply |=> done)
		else $error("pcm_datapath: update without result");

	// a word that is not forwarded carries no command
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.forward) |-> (result.cmd_out == '0))
		else $error("pcm_datapath: command word leaked");

	// forwarding implies success
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.forward) |-> result.done_ok)
		else $error("pcm_datapath: forward without done_ok");

endmodule

// ===== hdl/priority_command_mux.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_command_mux: priority slot table with activity timeout
// Connects command sources to priority levels and forwards a source's
// command only while no higher level has been heard within its timeout.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive item and raise start; the word is taken at a rising
//   edge where start is high and busy is low. busy stays high until the word
//   is fully processed.
//   Result channel: done is high for exactly one cycle with the result word
//   on result; the receiver cannot stall, so it must take the word then.
//   Every taken word yields exactly one result word.
//   Sequence: the scan walks the slot memories one slot a cycle, highest
//   slot first, then the drain state fills the read register stage and the
//   update cycle loads the result register.
//   No new word is taken while busy is high; the slot memories have a
//   single read port, which the scan of the current word uses.
//   A new word may be taken in the cycle its predecessor's result is shown.
//   Reset: all slots are free and unheard; no clearing pass is needed, the
//   block takes a word in the first cycle after reset.
// ----------------------------------------------------------------------------
module priority_command_mux #(
	parameter int LEVELS       = 16,
	parameter int PAYLOAD_BITS = 64,
	parameter int TIME_BITS    = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  pcm_pkg::item_t   item,
	output logic             done,
	output pcm_pkg::result_t result
);

	pcm_pkg::ctrl_cmd_t  cmd;
	pcm_pkg::dp_status_t status;

	// sequencer
	pcm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.status (status)
	);

	// slot table and scan
	pcm_datapath #(
		.LEVELS       (LEVELS),
		.PAYLOAD_BITS (PAYLOAD_BITS),
		.TIME_BITS    (TIME_BITS)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.status (status),
		.item   (item),
		.result (result),
		.done   (done)
	);

endmodule
